// File: rtl/b64e_pkg.sv
package b64e_pkg;

  // Default depth of the job queue between the front and the back part.
  localparam int QueueDepth = 2;

  localparam logic [5:0] SymLowerStart = 6'd26;
  localparam logic [5:0] SymDigitStart = 6'd52;
  localparam logic [5:0] SymPlus       = 6'd62;

  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharLowerA = 8'd97;
  localparam logic [7:0] CharZero   = 8'd48;
  localparam logic [7:0] CharPlus   = 8'd43;
  localparam logic [7:0] CharSlash  = 8'd47;
  localparam logic [7:0] CharPad    = 8'd61;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       is_last_byte;
  } b64e_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
  } b64e_out_t;

  // One accepted byte, classified: up to four slots, each a symbol or a pad.
  typedef struct packed {
    logic [3:0]      pad;
    logic [3:0][5:0] sym;
    logic [1:0]      last_idx;
    logic            msg_end;
  } b64e_job_t;

  function automatic logic [7:0] sym_char(input logic [5:0] v, input logic swap);
    logic [7:0] ch;
    if (v < SymLowerStart) begin
      ch = CharUpperA + {2'b00, v};
    end else if (v < SymDigitStart) begin
      ch = CharLowerA + {2'b00, v - SymLowerStart};
    end else if (v < SymPlus) begin
      ch = CharZero + {2'b00, v - SymDigitStart};
    end else if (v == SymPlus) begin
      ch = swap ? CharSlash : CharPlus;
    end else begin
      ch = swap ? CharPlus : CharSlash;
    end
    return ch;
  endfunction

endpackage

// File: rtl/base64_stream_encoder.sv
// Channel  | Ports                              | Direction | Transfer when
// ---------+------------------------------------+-----------+------------------------
// input    | in_valid, in_ready, in_data        | in        | in_valid && in_ready
// result   | out_valid, out_ready, out_data     | out       | out_valid && out_ready
// config   | cfg_wr_en, cfg_wr_data             | in        | cfg_wr_en (no wait)
//
// Each input byte is taken while the queue has room; the back part sends one character per
// cycle from its output register while not stalled, so a byte gives one character in phases
// zero and one, two in phase two and up to four when a final byte leaves a partial group; a
// steady stream gives four characters per three bytes. A byte's job passes through the queue
// into the output register. Synchronous reset on rst_n clears group state, queue, output
// valid and swap register. A result-side stall fills the queue and only then drops in_ready.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64e_pkg::b64e_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::b64e_out_t out_data
);

  localparam int JobW = $bits(b64e_pkg::b64e_job_t);

  // Front side: classified job for the byte under transfer.
  b64e_pkg::b64e_job_t front_job;
  logic                q_push;
  logic                q_full;

  // Back side: oldest pending job, read combinationally from the queue.
  logic [JobW-1:0]     q_rd_data;
  b64e_pkg::b64e_job_t q_head;
  logic                q_pop;
  logic                q_empty;

  assign q_head = b64e_pkg::b64e_job_t'(q_rd_data);

  // The front keeps the position within the three-byte group and the leftover bits,
  // and turns each byte into the symbols and pads that it causes.
  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (front_job)
  );

  // A short queue decouples byte intake from character output.
  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (JobW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (JobW'(front_job)),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The back walks the slots of each job, maps symbols to ASCII and drives the
  // result register.
  b64e_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// File: rtl/b64e_front.sv
module b64e_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  b64e_pkg::b64e_in_t   in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output b64e_pkg::b64e_job_t  q_job
);

  typedef enum logic [1:0] {PH_0, PH_1, PH_2} phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [7:0] b;
  logic       last;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign b        = in_data.byte_in;
  assign last     = in_data.is_last_byte;

  always_comb begin
    q_job         = '0;
    q_job.msg_end = last;
    phase_nxt     = phase_r;
    carry_nxt     = carry_r;
    unique case (phase_r)
      PH_1: begin
        q_job.sym[0] = {carry_r[1:0], b[7:4]};
        if (last) begin
          q_job.sym[1]   = {b[3:0], 2'b00};
          q_job.pad[2]   = 1'b1;
          q_job.last_idx = 2'd2;
        end
        carry_nxt = b[3:0];
        phase_nxt = PH_2;
      end
      PH_2: begin
        q_job.sym[0]   = {carry_r, b[7:6]};
        q_job.sym[1]   = b[5:0];
        q_job.last_idx = 2'd1;
        carry_nxt      = 4'd0;
        phase_nxt      = PH_0;
      end
      default: begin
        q_job.sym[0] = b[7:2];
        if (last) begin
          q_job.sym[1]   = {b[1:0], 4'b0000};
          q_job.pad[2]   = 1'b1;
          q_job.pad[3]   = 1'b1;
          q_job.last_idx = 2'd3;
        end
        carry_nxt = {2'b00, b[1:0]};
        phase_nxt = PH_1;
      end
    endcase
    if (last) begin
      carry_nxt = 4'd0;
      phase_nxt = PH_0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      carry_r <= 4'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && last) |=> (phase_r == PH_0 && carry_r == 4'd0))
    else $error("group state not cleared after final byte");

  a_phase2_empties_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && phase_r == PH_2) |=> (carry_r == 4'd0))
    else $error("carry left over after a completed group");

  a_carry_narrow_in_ph1: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_1) |-> (carry_r[3:2] == 2'b00))
    else $error("carry holds more than two bits in phase one");

endmodule

// File: rtl/b64e_fifo.sv
module b64e_fifo #(
  parameter int DEPTH = b64e_pkg::QueueDepth,
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [IdxW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  count_r;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("queue occupancy out of range");

endmodule

// File: rtl/b64e_back.sv
module b64e_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  b64e_pkg::b64e_job_t  q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b64e_pkg::b64e_out_t  out_data
);

  logic                swap_r;
  logic [1:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  b64e_pkg::b64e_out_t out_data_r, out_data_nxt;
  logic                load;
  logic                slot_last;

  assign load      = !q_empty && (!out_valid_r || out_ready);
  assign slot_last = (idx_r == q_head.last_idx);
  assign q_pop     = load && slot_last;

  always_comb begin
    out_data_nxt.out_char    = q_head.pad[idx_r] ? b64e_pkg::CharPad
                                                 : b64e_pkg::sym_char(q_head.sym[idx_r], swap_r);
    out_data_nxt.run_last    = slot_last;
    out_data_nxt.message_end = slot_last && q_head.msg_end;
    idx_nxt                  = idx_r;
    if (load) begin
      idx_nxt = slot_last ? 2'd0 : idx_r + 2'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        swap_r <= cfg_wr_data;
      end
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.message_end) |-> out_data_r.run_last)
    else $error("message end flagged on a non-final character");

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r <= q_head.last_idx))
    else $error("slot index past the end of the current job");

  a_idx_home_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (idx_r == 2'd0))
    else $error("slot index not at start while queue is empty");

endmodule
